// ----- rtl/tce_pkg.sv -----
package tce_pkg;

  // Field widths fixed by the interface
  localparam int DATA_W      = 32;
  localparam int PROD_W      = 64;
  localparam int MAX_ITER_W  = 16;
  localparam int COLOR_W     = 21;
  localparam int CFG_IDX_W   = 2;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_C_REAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C_IMAG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd2;

  // Register reset values
  localparam logic [MAX_ITER_W-1:0] MAX_ITER_RESET = 16'd1000;

  // Escape radius squared (integer part) and color code constants
  localparam int ESCAPE_NORM  = 10;
  localparam int COLOR_SHIFT  = 3;   // count * 8
  localparam int COLOR_LOWER  = 21;

  // Saturation bounds of a Q6.26 word, held at product width
  localparam logic signed [PROD_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // take a new starting point
    logic mul;      // register the three products
    logic iterate;  // write back the next point, bump the count
    logic emit;     // move the result into the output register
  } tce_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic at_limit;  // count equals the iteration limit
    logic escape;    // norm reached the escape threshold
    logic out_free;  // output register can take a beat this cycle
  } tce_status_t;

  // Clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/tricorn_escape_time_unit.sv -----
// Tricorn escape-time unit: one starting point in, one result beat out.
// Input stalls from acceptance until the result enters the output register.
// Each iteration: multiply step, then update step via the shared product registers.
// The next point is taken while the previous result waits in the output register.
// Synchronous active-high reset: idle, no result held, c = 0, max_iter = 1000.
module tricorn_escape_time_unit #(
  parameter int COUNT_WIDTH = 16,
  parameter int FRAC_BITS   = 26
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [tce_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tce_pkg::DATA_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [tce_pkg::DATA_W-1:0]     z_real,
  input  logic signed [tce_pkg::DATA_W-1:0]     z_imag,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  escaped,
  output logic [COUNT_WIDTH-1:0]                iter_count,
  output logic                                  lower_half,
  output logic signed [tce_pkg::COLOR_W-1:0]    color_code
);

  tce_pkg::tce_cmd_t    cmd;
  tce_pkg::tce_status_t status;

  tce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tce_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .z_real     (z_real),
    .z_imag     (z_imag),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .escaped    (escaped),
    .iter_count (iter_count),
    .lower_half (lower_half),
    .color_code (color_code)
  );

endmodule

// ----- rtl/tce_ctrl.sv -----
module tce_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tce_pkg::tce_status_t status,
  output tce_pkg::tce_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_STEP = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Input side is open only between items
  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        if (status.at_limit || status.escape) begin
          state_next = S_OUT;
        end else begin
          cmd.iterate = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // An accepted beat always starts a multiply pass
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_MUL))
    else $error("accepted beat did not start an iteration");

  // Result only moves into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result emitted into a full output register");

  // Never iterate past an exit condition
  a_no_step_on_exit: assert property (@(posedge clk) disable iff (rst)
    cmd.iterate |-> (!status.at_limit && !status.escape))
    else $error("iteration issued after exit condition");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state register not one-hot");
`endif

endmodule

// ----- rtl/tce_datapath.sv -----
module tce_datapath #(
  parameter int COUNT_WIDTH = 16,
  parameter int FRAC_BITS   = 26
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tce_pkg::tce_cmd_t                     cmd,
  output tce_pkg::tce_status_t                  status,
  input  logic                                  cfg_write,
  input  logic [tce_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tce_pkg::DATA_W-1:0]            cfg_data,
  input  logic signed [tce_pkg::DATA_W-1:0]     z_real,
  input  logic signed [tce_pkg::DATA_W-1:0]     z_imag,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  escaped,
  output logic [COUNT_WIDTH-1:0]                iter_count,
  output logic                                  lower_half,
  output logic signed [tce_pkg::COLOR_W-1:0]    color_code
);

  localparam int LimW    = (COUNT_WIDTH < tce_pkg::MAX_ITER_W) ? COUNT_WIDTH
                                                              : tce_pkg::MAX_ITER_W;
  localparam int ColSumW = COUNT_WIDTH + 5;
  localparam int ThrShift = 2 * FRAC_BITS;
  // Escape threshold 10 * 2^(2*FRAC_BITS); past 60 bits of shift it never trips
  localparam logic [tce_pkg::PROD_W-1:0] EscThr =
    (ThrShift <= 60) ? (64'(tce_pkg::ESCAPE_NORM) << ThrShift) : {64{1'b1}};

  // Configuration registers
  logic signed [tce_pkg::DATA_W-1:0]     c_real;
  logic signed [tce_pkg::DATA_W-1:0]     c_imag;
  logic [tce_pkg::MAX_ITER_W-1:0]        max_iter;

  // Iteration state
  logic signed [tce_pkg::DATA_W-1:0]     xr;
  logic signed [tce_pkg::DATA_W-1:0]     xi;
  logic [COUNT_WIDTH-1:0]                n;
  logic signed [tce_pkg::PROD_W-1:0]     sq_r;
  logic signed [tce_pkg::PROD_W-1:0]     sq_i;
  logic signed [tce_pkg::PROD_W-1:0]     prod_ri;

  logic [COUNT_WIDTH-1:0]                limit;
  logic [tce_pkg::PROD_W-1:0]            norm;
  logic signed [tce_pkg::PROD_W-1:0]     diff;
  logic signed [tce_pkg::PROD_W-1:0]     neg_p;
  logic signed [tce_pkg::PROD_W-1:0]     re_full;
  logic signed [tce_pkg::PROD_W-1:0]     im_full;
  logic signed [tce_pkg::DATA_W-1:0]     xr_next;
  logic signed [tce_pkg::DATA_W-1:0]     xi_next;
  logic [ColSumW-1:0]                    col_sum;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      c_real   <= '0;
      c_imag   <= '0;
      max_iter <= tce_pkg::MAX_ITER_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tce_pkg::REG_C_REAL:   c_real   <= cfg_data;
        tce_pkg::REG_C_IMAG:   c_imag   <= cfg_data;
        tce_pkg::REG_MAX_ITER: max_iter <= cfg_data[tce_pkg::MAX_ITER_W-1:0];
        default: ;
      endcase
    end
  end

  assign limit = COUNT_WIDTH'(max_iter[LimW-1:0]);

  // Products, one register stage
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sq_r    <= xr * xr;
      sq_i    <= xi * xi;
      prod_ri <= xr * xi;
    end
  end

  // Norm test and next point from the registered products
  always_comb begin
    norm    = $unsigned(sq_r) + $unsigned(sq_i);
    diff    = sq_r - sq_i;
    neg_p   = -prod_ri;
    re_full = (diff >>> FRAC_BITS) + tce_pkg::PROD_W'(c_real);
    im_full = (neg_p >>> (FRAC_BITS - 1)) + tce_pkg::PROD_W'(c_imag);
    xr_next = tce_pkg::sat_data(re_full);
    xi_next = tce_pkg::sat_data(im_full);
  end

  // Point and count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xr <= z_real;
      xi <= z_imag;
      n  <= '0;
    end else if (cmd.iterate) begin
      xr <= xr_next;
      xi <= xi_next;
      n  <= n + COUNT_WIDTH'(1);
    end
  end

  assign status.at_limit = (n == limit);
  assign status.escape   = (norm >= EscThr);
  assign status.out_free = !out_valid || !out_stall;

  // Color: count*8, plus 21 below the real axis
  assign col_sum = (ColSumW'(n) << tce_pkg::COLOR_SHIFT)
                 + (xi[tce_pkg::DATA_W-1] ? ColSumW'(tce_pkg::COLOR_LOWER) : '0);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      escaped    <= !status.at_limit;
      iter_count <= n;
      lower_half <= xi[tce_pkg::DATA_W-1];
      color_code <= status.at_limit ? '1 : tce_pkg::COLOR_W'(col_sum);
    end
  end

`ifndef SYNTHESIS
  // Each iteration advances the count by exactly one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.iterate |=> (n == COUNT_WIDTH'($past(n) + COUNT_WIDTH'(1))))
    else $error("iteration count did not advance by one");

  // A fresh point starts from count zero
  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (n == '0))
    else $error("count not cleared on a new point");

  // An emitted result is presented on the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");
`endif

endmodule
